// ===== rtl/sdofq_pkg.sv =====
package sdofq_pkg;

  localparam int SLOT_COUNT_DEF = 64;
  localparam int CAP_RESET      = 12;
  localparam int PAYLOAD_W      = 64;
  localparam int CAP_W          = 7;
  localparam int COUNT_W        = 7;

  localparam logic [1:0] ACT_PUSH  = 2'd0;
  localparam logic [1:0] ACT_POP   = 2'd1;
  localparam logic [1:0] ACT_TAKE  = 2'd2;
  localparam logic [1:0] ACT_CLEAR = 2'd3;

  localparam logic [2:0] RK_ACCEPTED     = 3'd0;
  localparam logic [2:0] RK_OUT_OF_ORDER = 3'd1;
  localparam logic [2:0] RK_RETURNED     = 3'd2;
  localparam logic [2:0] RK_EMPTY        = 3'd3;
  localparam logic [2:0] RK_CLEARED      = 3'd4;

  typedef struct packed {
    logic [1:0]           action;
    logic [31:0]          src_id;
    logic [31:0]          epoch;
    logic [63:0]          seq;
    logic                 reserved_nonzero;
    logic [PAYLOAD_W-1:0] payload;
  } in_req_t;

  typedef struct packed {
    logic [2:0]           result_kind;
    logic [31:0]          out_src_id;
    logic [31:0]          out_epoch;
    logic [63:0]          out_seq;
    logic [PAYLOAD_W-1:0] out_payload;
    logic [63:0]          out_gen;
    logic [COUNT_W-1:0]   fill_level;
    logic [COUNT_W-1:0]   entries_dropped;
    logic                 epoch_restart;
    logic                 reserved_warned;
    logic [63:0]          drop_total;
    logic [63:0]          out_of_order_total;
  } out_res_t;

  typedef struct packed {
    logic load;    // latch request and read the slot memory
    logic cfg_wr;  // apply a capacity write
    logic commit;  // execute the latched request and load the result register
  } ctrl_cmd_t;

endpackage

// ===== rtl/sdofq_ctrl.sv =====
module sdofq_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  output sdofq_pkg::ctrl_cmd_t cmd
);
  import sdofq_pkg::*;

  typedef enum logic {S_IDLE, S_EXEC} state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    cmd           = '0;
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    cfg_ready     = 1'b0;
    in_ready      = 1'b0;
    if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      S_IDLE: begin
        // configuration writes take priority over requests
        cfg_ready  = 1'b1;
        in_ready   = !cfg_valid;
        cmd.cfg_wr = cfg_valid;
        cmd.load   = in_valid && !cfg_valid;
        if (cmd.load) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        // hold until the result register is free
        if (!out_valid_r || out_ready) begin
          cmd.commit    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

// ===== rtl/sdofq_dp.sv =====
module sdofq_dp #(
  parameter int SLOT_COUNT = sdofq_pkg::SLOT_COUNT_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  sdofq_pkg::ctrl_cmd_t          cmd,
  input  sdofq_pkg::in_req_t            in_req,
  input  logic [sdofq_pkg::CAP_W-1:0]   cfg_data,
  output sdofq_pkg::out_res_t           out_res
);
  import sdofq_pkg::*;

  localparam int IW       = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int CW       = $clog2(SLOT_COUNT + 1);
  localparam int SW       = CW + 1;
  localparam int CAP_INIT = (CAP_RESET > SLOT_COUNT) ? SLOT_COUNT : CAP_RESET;

  typedef struct packed {
    logic [31:0]          src_id;
    logic [31:0]          epoch;
    logic [63:0]          seq;
    logic [PAYLOAD_W-1:0] payload;
    logic [63:0]          generation;
  } slot_t;

  slot_t mem [SLOT_COUNT];

  in_req_t     req_r;
  slot_t       rd_r;
  out_res_t    res_r, res_nxt;
  logic [IW-1:0] head_r, head_nxt;
  logic [CW-1:0] held_r, held_nxt;
  logic [CW-1:0] cap_r, cap_nxt;
  logic          have_r, have_nxt;
  logic [31:0]   last_stream_r, last_stream_nxt;
  logic [31:0]   prev_epoch_r, prev_epoch_nxt;
  logic [63:0]   prev_seq_r, prev_seq_nxt;
  logic [63:0]   gen_r, gen_nxt;
  logic [63:0]   drop_r, drop_nxt;
  logic [63:0]   ooo_r, ooo_nxt;

  logic          wr_en;
  logic [IW-1:0] wr_idx;
  slot_t         wr_slot;

  logic [SW-1:0] take_sum;
  logic [IW-1:0] rd_addr;

  // newest entry sits at (head + held - 1) mod capacity
  always_comb begin
    take_sum = SW'(head_r) + SW'(held_r) - SW'(1);
    if (take_sum >= SW'(cap_r)) begin
      take_sum = take_sum - SW'(cap_r);
    end
    rd_addr = (in_req.action == ACT_TAKE) ? take_sum[IW-1:0] : head_r;
  end

  always_comb begin
    logic [CW-1:0] cfg_cap;
    logic          ooo;
    logic          reset_epoch;
    logic          flush;
    logic          evict;
    logic [SW-1:0] held1, head1, d1, head_inc, head2, held2, d2, ins;

    head_nxt        = head_r;
    held_nxt        = held_r;
    cap_nxt         = cap_r;
    have_nxt        = have_r;
    last_stream_nxt = last_stream_r;
    prev_epoch_nxt  = prev_epoch_r;
    prev_seq_nxt    = prev_seq_r;
    gen_nxt         = gen_r;
    drop_nxt        = drop_r;
    ooo_nxt         = ooo_r;
    res_nxt         = res_r;
    wr_en           = 1'b0;
    wr_idx          = '0;
    wr_slot         = '0;

    if (cfg_data == '0) begin
      cfg_cap = CW'(1);
    end else if (int'(cfg_data) > SLOT_COUNT) begin
      cfg_cap = CW'(SLOT_COUNT);
    end else begin
      cfg_cap = CW'(cfg_data);
    end

    ooo = have_r && (req_r.src_id == last_stream_r) && (req_r.epoch == prev_epoch_r) &&
          (req_r.seq <= prev_seq_r);
    reset_epoch = have_r && (req_r.epoch != prev_epoch_r);
    flush       = reset_epoch && (held_r != '0);
    held1       = flush ? '0 : SW'(held_r);
    head1       = flush ? '0 : SW'(head_r);
    d1          = flush ? SW'(held_r) : '0;
    evict       = held1 >= SW'(cap_r);
    head_inc    = head1 + SW'(1);
    if (!evict) begin
      head2 = head1;
    end else if (head_inc >= SW'(cap_r)) begin
      head2 = '0;
    end else begin
      head2 = head_inc;
    end
    held2 = evict ? held1 - SW'(1) : held1;
    d2    = d1 + SW'(evict);
    ins   = head2 + held2;
    if (ins >= SW'(cap_r)) begin
      ins = ins - SW'(cap_r);
    end

    if (cmd.cfg_wr && (cfg_cap != cap_r)) begin
      drop_nxt = drop_r + 64'(held_r);
      cap_nxt  = cfg_cap;
      head_nxt = '0;
      held_nxt = '0;
    end

    if (cmd.commit) begin
      res_nxt = '0;
      case (req_r.action)
        ACT_PUSH: begin
          res_nxt.reserved_warned = req_r.reserved_nonzero;
          if (ooo) begin
            ooo_nxt             = ooo_r + 64'd1;
            res_nxt.result_kind = RK_OUT_OF_ORDER;
          end else begin
            have_nxt        = 1'b1;
            last_stream_nxt = req_r.src_id;
            prev_epoch_nxt  = req_r.epoch;
            prev_seq_nxt    = req_r.seq;
            gen_nxt         = gen_r + 64'd1;
            drop_nxt        = drop_r + 64'(d2);
            head_nxt        = head2[IW-1:0];
            held_nxt        = CW'(held2 + SW'(1));
            wr_en           = 1'b1;
            wr_idx          = ins[IW-1:0];
            wr_slot         = '{src_id: req_r.src_id, epoch: req_r.epoch,
                                seq: req_r.seq, payload: req_r.payload,
                                generation: gen_nxt};
            res_nxt.result_kind     = RK_ACCEPTED;
            res_nxt.out_gen         = gen_nxt;
            res_nxt.entries_dropped = COUNT_W'(d2);
            res_nxt.epoch_restart   = reset_epoch;
          end
        end
        ACT_POP, ACT_TAKE: begin
          if (held_r == '0) begin
            res_nxt.result_kind = RK_EMPTY;
          end else begin
            res_nxt.result_kind = RK_RETURNED;
            res_nxt.out_src_id  = rd_r.src_id;
            res_nxt.out_epoch   = rd_r.epoch;
            res_nxt.out_seq     = rd_r.seq;
            res_nxt.out_payload = rd_r.payload;
            res_nxt.out_gen     = rd_r.generation;
            if (req_r.action == ACT_POP) begin
              head_inc = SW'(head_r) + SW'(1);
              head_nxt = (head_inc >= SW'(cap_r)) ? '0 : head_inc[IW-1:0];
              held_nxt = held_r - CW'(1);
            end else begin
              head_nxt = '0;
              held_nxt = '0;
            end
          end
        end
        default: begin
          head_nxt            = '0;
          held_nxt            = '0;
          have_nxt            = 1'b0;
          res_nxt.result_kind = RK_CLEARED;
        end
      endcase
      res_nxt.fill_level         = COUNT_W'(held_nxt);
      res_nxt.drop_total         = drop_nxt;
      res_nxt.out_of_order_total = ooo_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= wr_slot;
    end
    if (cmd.load) begin
      rd_r  <= mem[rd_addr];
      req_r <= in_req;
    end
    res_r <= res_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r        <= '0;
      held_r        <= '0;
      cap_r         <= CW'(CAP_INIT);
      have_r        <= 1'b0;
      last_stream_r <= '0;
      prev_epoch_r  <= '0;
      prev_seq_r    <= '0;
      gen_r         <= '0;
      drop_r        <= '0;
      ooo_r         <= '0;
    end else begin
      head_r        <= head_nxt;
      held_r        <= held_nxt;
      cap_r         <= cap_nxt;
      have_r        <= have_nxt;
      last_stream_r <= last_stream_nxt;
      prev_epoch_r  <= prev_epoch_nxt;
      prev_seq_r    <= prev_seq_nxt;
      gen_r         <= gen_nxt;
      drop_r        <= drop_nxt;
      ooo_r         <= ooo_nxt;
    end
  end

  assign out_res = res_r;

endmodule

// ===== rtl/sequenced_drop_oldest_frame_queue_unit.sv =====
// Bounded ring queue of decoded messages with an out-of-order filter.
// Requests arrive on in_valid/in_ready with one in_req: push, pop oldest,
// take latest (empties the queue) or clear. Each request yields exactly one
// result on out_valid/out_ready carrying the kind, the returned entry, the
// queue depth and the running drop and out-of-order totals.
// cfg_valid/cfg_ready/cfg_data sets the capacity (clamped to 1..SLOT_COUNT);
// a changed capacity flushes the queue and counts its entries as drops.
// A request is latched with a registered read of the slot memory, then
// executed into the result register once that register is free; a new
// request is taken only after the previous one has executed.
// Reset: capacity returns to 12 (at most SLOT_COUNT), queue, stream memory,
// generation and counters clear; slot memory is not cleared and its contents
// are only used while it holds a queued entry.
// A stalled receiver does not stop acceptance: the next request is taken and
// its slot read is done, then it waits until the result register is free.
module sequenced_drop_oldest_frame_queue_unit #(
  parameter int SLOT_COUNT = sdofq_pkg::SLOT_COUNT_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  sdofq_pkg::in_req_t          in_req,
  output logic                        out_valid,
  input  logic                        out_ready,
  output sdofq_pkg::out_res_t         out_res,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [sdofq_pkg::CAP_W-1:0] cfg_data
);
  import sdofq_pkg::*;

  ctrl_cmd_t cmd;

  sdofq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  sdofq_dp #(
    .SLOT_COUNT (SLOT_COUNT)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .in_req   (in_req),
    .cfg_data (cfg_data),
    .out_res  (out_res)
  );

  a_no_cfg_with_req: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |-> !(cfg_valid && cfg_ready))
    else $error("request and capacity write accepted together");

  a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready && !cfg_ready)
    else $error("request taken while another is in flight");

  a_commit_shows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> out_valid)
    else $error("executed request produced no result");

  a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (int'(out_res.fill_level) <= SLOT_COUNT))
    else $error("queue depth beyond memory size");

endmodule
